// ===== rtl/cdes_pkg.sv =====
// Shared constants and beat types for the centroid distance error sum unit.
// No dependencies; every other file imports this package.
package cdes_pkg;

  localparam int MAX_DIM     = 128;
  localparam int CIDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IDX_W       = 7;
  localparam int COORD_W     = 16;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int MUL_CNT_W   = $clog2(COORD_W);
  localparam int SQ_W        = 40;
  localparam int FRAC_SHIFT  = 16;
  localparam int RAD_W       = SQ_W + FRAC_SHIFT;
  localparam int DIST_W      = RAD_W / 2;
  localparam int SQRT_STEPS  = RAD_W / 2;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
  localparam int REM_W       = DIST_W + 3;
  localparam int TOT_W       = 48;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   coord_index;
    logic [COORD_W-1:0] coord_value;
    logic               last_coord;
    logic               first_point;
    logic               last_point;
  } in_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] point_distance;
    logic [TOT_W-1:0]  total_error;
    logic              range_done;
  } out_beat_t;

endpackage

// ===== rtl/cdes_centroid_ram.sv =====
// Centroid coordinate store: one write port, one registered read port.
// Depends on cdes_pkg for depth and widths.
module cdes_centroid_ram import cdes_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [CIDX_W-1:0]  wr_addr,
  input  logic [COORD_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [CIDX_W-1:0]  rd_addr,
  output logic [COORD_W-1:0] rd_data
);

  logic [COORD_W-1:0] mem [MAX_DIM];
  logic [COORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cdes_sq_mul.sv =====
// Bit-serial squarer: shift-add over one multiplier bit per cycle.
// Depends on cdes_pkg for widths.
module cdes_sq_mul import cdes_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] operand,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  logic [COORD_W-1:0]   mcand_r;
  logic [PROD_W-1:0]    prod_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [COORD_W:0]     psum;

  always_comb begin
    psum = {1'b0, prod_r[PROD_W-1:COORD_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(COORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      mcand_r <= operand;
      prod_r  <= {{COORD_W{1'b0}}, operand};
    end else if (busy_r) begin
      prod_r <= {psum, prod_r[COORD_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

// ===== rtl/cdes_isqrt.sv =====
// Digit-serial integer square root: two radicand bits, one root bit per cycle.
// Depends on cdes_pkg for widths and step count.
module cdes_isqrt import cdes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [DIST_W-1:0]     root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
    trial  = REM_W'({root_r, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[DIST_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/centroid_distance_error_sum_unit.sv =====
// A centroid load is written straight to the centroid store; a point coordinate
// passes through the 16-step bit-serial squarer, and a point's last coordinate
// also runs the 28-step digit-serial square root. One item at a time.
// A result waits in the output register while the next item is taken.
// Reset clears control, square sum and total; the centroid store is not cleared.
module centroid_distance_error_sum_unit import cdes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SQRT,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  in_beat_t           item_r, item_nxt;
  logic               idx_ok_r, idx_ok_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               in_acc;
  logic               idx_in_range;
  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [CIDX_W-1:0]  ram_addr;
  logic [COORD_W-1:0] ram_rd_data;
  logic [COORD_W-1:0] cen;
  logic [COORD_W-1:0] diff;
  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [SQ_W:0]      sq_sum;
  logic [SQ_W-1:0]    sq_sat;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [DIST_W-1:0]  dist_val;
  logic [TOT_W-1:0]   tot_base;
  logic [TOT_W:0]     tot_sum;
  logic               out_free;

  assign in_stall     = (state_r != ST_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign idx_in_range = (32'(in_data.coord_index) < MAX_DIM);
  assign ram_addr     = CIDX_W'(in_data.coord_index);
  assign ram_wr_en    = in_acc && (in_data.cmd == CMD_LOAD) && idx_in_range;
  assign ram_rd_en    = in_acc && (in_data.cmd == CMD_POINT);

  cdes_centroid_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (in_data.coord_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  assign cen       = idx_ok_r ? ram_rd_data : '0;
  assign diff      = (item_r.coord_value >= cen) ? (item_r.coord_value - cen)
                                                 : (cen - item_r.coord_value);
  assign mul_start = (state_r == ST_READ);

  cdes_sq_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (diff),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign sq_sum     = {1'b0, sq_r} + (SQ_W + 1)'(mul_prod);
  assign sq_sat     = sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
  assign sqrt_start = (state_r == ST_MUL) && mul_done && item_r.last_coord;

  cdes_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sq_sat, {FRAC_SHIFT{1'b0}}}),
    .done     (sqrt_done),
    .root     (dist_val)
  );

  assign tot_base = item_r.first_point ? '0 : total_r;
  assign tot_sum  = {1'b0, tot_base} + (TOT_W + 1)'(dist_val);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_ok_nxt    = idx_ok_r;
    sq_nxt        = sq_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.cmd == CMD_POINT)) begin
          item_nxt   = in_data;
          idx_ok_nxt = idx_in_range;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (item_r.last_coord) begin
            sq_nxt    = '0;
            state_nxt = ST_SQRT;
          end else begin
            sq_nxt    = sq_sat;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          total_nxt                   = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
          out_valid_nxt               = 1'b1;
          out_data_nxt.point_distance = dist_val;
          out_data_nxt.total_error    = total_nxt;
          out_data_nxt.range_done     = item_r.last_point;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sq_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_r        <= sq_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_ok_r   <= idx_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sq_clear_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (sq_r == '0))
    else $error("square sum not cleared during square root");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("squarer finished outside multiply state");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == ST_SQRT))
    else $error("square root finished outside root state");

  a_out_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside emit state");

endmodule

// ===== tb/tb.sv =====
// Testbench for centroid_distance_error_sum_unit: a queued driver, a stall generator and
// a result monitor, checked against an in-line distance and total predictor.
// Depends on cdes_pkg and the unit's RTL only.
module tb;
  import cdes_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  centroid_distance_error_sum_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  in_beat_t          beat_plan [$];
  out_beat_t         dist_q [$];
  bit [COORD_W-1:0]  cen_plan [MAX_DIM];
  bit                cen_set [MAX_DIM];
  logic [IDX_W-1:0]  set_list [$];
  logic [COORD_W-1:0] cen_mem [MAX_DIM];
  logic [SQ_W-1:0]   sq_acc = '0;
  logic [TOT_W-1:0]  tot_acc = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int planned = 0;
  int bad_cnt = 0;
  int loads_seen = 0;
  int coords_seen = 0;
  int results_seen = 0;
  int ranges_seen = 0;
  bit sq_sat_seen = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [DIST_W-1:0] root_of(input logic [RAD_W-1:0] rad);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] one;
    rem = 64'(rad);
    res = '0;
    one = 64'd1 << 62;
    while (one > rem) one = one >> 2;
    while (one != 0) begin
      if (rem >= res + one) begin
        rem = rem - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res[DIST_W-1:0];
  endfunction

  task automatic track_beat(input in_beat_t b);
    logic [COORD_W-1:0] cen;
    logic [COORD_W-1:0] dif;
    logic [SQ_W:0]      sq_next;
    logic [TOT_W:0]     tot_next;
    out_beat_t          r;
    if (b.cmd == CMD_LOAD) begin
      loads_seen++;
      if (b.coord_index < MAX_DIM) cen_mem[b.coord_index] = b.coord_value;
    end else begin
      coords_seen++;
      cen = (b.coord_index < MAX_DIM) ? cen_mem[b.coord_index] : '0;
      dif = (b.coord_value >= cen) ? b.coord_value - cen : cen - b.coord_value;
      sq_next = sq_acc + dif * dif;
      if (sq_next[SQ_W]) begin
        sq_acc = '1;
        sq_sat_seen = 1'b1;
      end else begin
        sq_acc = sq_next[SQ_W-1:0];
      end
      if (b.last_coord) begin
        r.point_distance = root_of(RAD_W'(sq_acc) << FRAC_SHIFT);
        tot_next = (b.first_point ? '0 : tot_acc) + r.point_distance;
        tot_acc = tot_next[TOT_W] ? '1 : tot_next[TOT_W-1:0];
        r.total_error = tot_acc;
        r.range_done = b.last_point;
        dist_q = {dist_q, r};
        sq_acc = '0;
      end
    end
  endtask

  function automatic logic [COORD_W-1:0] pick_value(input logic [IDX_W-1:0] idx);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return cen_plan[idx];
      3: return cen_plan[idx] + COORD_W'($urandom_range(3)) - COORD_W'(1);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    in_beat_t b;
    b.cmd = CMD_LOAD;
    b.coord_index = idx;
    b.coord_value = val;
    b.last_coord = 1'($urandom);
    b.first_point = 1'($urandom);
    b.last_point = 1'($urandom);
    beat_plan = {beat_plan, b};
    planned++;
    cen_plan[idx] = val;
    if (!cen_set[idx]) begin
      cen_set[idx] = 1'b1;
      set_list = {set_list, idx};
    end
  endtask

  task automatic queue_coord(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] val,
                             input logic lc, input logic fp, input logic lp);
    in_beat_t b;
    b.cmd = CMD_POINT;
    b.coord_index = idx;
    b.coord_value = val;
    b.last_coord = lc;
    b.first_point = lc ? fp : 1'($urandom);
    b.last_point = lc ? lp : 1'($urandom);
    beat_plan = {beat_plan, b};
    planned++;
  endtask

  task automatic queue_point(input int n, input logic fp, input logic lp);
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0) begin
        idx = IDX_W'($urandom);
        queue_load(idx, pick_value(idx));
      end
      idx = set_list[$urandom_range(set_list.size() - 1)];
      queue_coord(idx, pick_value(idx), k == n - 1, fp, lp);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_beat(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (beat_plan.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= beat_plan.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.range_done) ranges_seen++;
      if (dist_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $display("unexpected beat: dist=%0d total=%0d done=%0b",
                   out_data.point_distance, out_data.total_error, out_data.range_done);
        end
      end else begin
        want = dist_q.pop_front();
        if (out_data.point_distance !== want.point_distance ||
            out_data.total_error !== want.total_error ||
            out_data.range_done !== want.range_done) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("mismatch: expected dist=%0d total=%0d done=%0b,",
                     want.point_distance, want.total_error, want.range_done,
                     " got dist=%0d total=%0d done=%0b",
                     out_data.point_distance, out_data.total_error, out_data.range_done);
          end
        end
      end
    end
  end

  initial begin
    int goal;
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 70, 0, 24};
    recv_pct = '{0, 0, 70, 24};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 0) begin
        queue_load(7'd0, 16'h0000);
        queue_load(7'd127, 16'hFFFF);
        queue_load(7'd1, 16'hFFFF);
        queue_load(7'd2, 16'h8000);
        queue_load(7'd64, 16'h5555);
        queue_load(7'd64, 16'hAAAA);
        queue_coord(7'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        queue_coord(7'd127, 16'h0000, 1'b1, 1'b1, 1'b0);
        queue_coord(7'd1, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        queue_coord(7'd64, 16'h5555, 1'b0, 1'b1, 1'b1);
        queue_coord(7'd2, 16'h7FFF, 1'b0, 1'b1, 1'b1);
        queue_coord(7'd2, 16'h8000, 1'b1, 1'b1, 1'b1);
        queue_coord(7'd1, 16'h0000, 1'b1, 1'b1, 1'b0);
        queue_load(7'd3, 16'h0000);
        for (int k = 0; k < 260; k++) begin
          queue_coord(7'd3, 16'hFFFF, k == 259, 1'b0, 1'b1);
        end
      end
      goal = planned + 270;
      while (planned < goal) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            queue_load(IDX_W'($urandom), COORD_W'($urandom));
          end
        end else begin
          queue_point(($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6),
                      $urandom_range(3) == 0, $urandom_range(3) == 0);
        end
      end
      while (beat_plan.size() != 0 || in_valid || dist_q.size() != 0) @(posedge clk);
      repeat (64) @(posedge clk);
    end
    $display("Ran %0d centroid loads and %0d point coordinates over four stall mixes;",
             loads_seen, coords_seen);
    $display("checked %0d distances, %0d range ends, square-sum saturation hit: %0b",
             results_seen, ranges_seen, sq_sat_seen);
    if (bad_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
